// File: hw/rtl/s2i_pkg.sv
// Shared types and constants for the string to integer parser.
package s2i_pkg;

    // Default width of the byte offset counters
    localparam int OFFSET_BITS_DEF = 16;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 88;
    localparam int VALUE_W     = 64;
    localparam int END_OFS_W   = 16;
    localparam int BASE_W      = 5;

    // Radix constants
    localparam logic [BASE_W-1:0] BASE_AUTO = 5'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 5'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 5'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 5'd16;

    // Configuration register indexes
    localparam logic REG_NUMBER_BASE = 1'b0;
    localparam logic REG_SIGNED_MODE = 1'b1;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_CASE  = 8'h20;

    // Parse phases
    typedef enum logic [2:0] {
        PH_START     = 3'd0,
        PH_AFTER_NEG = 3'd1,
        PH_ZERO_AUTO = 3'd2,
        PH_AUTO_X    = 3'd3,
        PH_HEX_ZERO  = 3'd4,
        PH_DIGITS    = 3'd5,
        PH_DONE      = 3'd6
    } phase_t;

    // One classified request as it travels from front to back
    typedef struct packed {
        logic [3:0] digit;
        logic       is_hex;
        logic       is_x;
        logic       is_zero;
        logic       is_minus;
        logic       start;
    } item_t;

endpackage

// File: hw/rtl/s2i_front.sv
// Front end: accepts bytes and classifies them for the parse back end.
module s2i_front
    import s2i_pkg::*;
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,   // [7:0] char_byte
    input  logic [0:0]            s_tuser,   // [0] string_start
    input  logic                  q_full,
    output logic                  q_push,
    output item_t                 q_item
);

    // Accept whenever the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Classify the byte: hex digit value, 'x' in either case, zero, minus
    always_comb
    begin
        logic [7:0] c;
        c             = s_tdata;
        q_item.digit  = 4'd0;
        q_item.is_hex = 1'b0;
        if (c inside {[8'h30:8'h39]})
        begin
            q_item.digit  = 4'(c - 8'h30);
            q_item.is_hex = 1'b1;
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            q_item.digit  = 4'(c - 8'h57);
            q_item.is_hex = 1'b1;
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            q_item.digit  = 4'(c - 8'h37);
            q_item.is_hex = 1'b1;
        end
        q_item.is_x     = ((c | CH_CASE) == CH_LOW_X);
        q_item.is_zero  = (c == CH_ZERO);
        q_item.is_minus = (c == CH_MINUS);
        q_item.start    = s_tuser[0];
    end

endmodule

// File: hw/rtl/s2i_queue.sv
// Short queue of classified requests between front and back.
module s2i_queue
    import s2i_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output item_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Advance pointers with wrap at the queue depth and update the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/s2i_back.sv
// Back end: parse state, digit accumulation and the registered result stage.
module s2i_back
    import s2i_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [BASE_W-1:0]      number_base,
    input  logic                   signed_mode,
    input  logic                   q_valid,
    input  item_t                  q_item,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int EXT_W = (OFFSET_BITS > END_OFS_W) ? OFFSET_BITS : END_OFS_W;

    phase_t                 phase_reg, phase_next;
    logic [VALUE_W-1:0]     acc_reg, acc_next;
    logic [VALUE_W-1:0]     nacc_reg, nacc_next;
    logic [BASE_W-1:0]      base_reg, base_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] end_reg, end_next;
    logic                   neg_reg, neg_next;
    logic                   taken;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [EXT_W-1:0]       end_ext;
    logic [END_OFS_W-1:0]   end_ofs;

    // Take the next request when the result stage is free or draining
    assign q_pop    = q_valid && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Parse step for the request at the head of the queue
    always_comb
    begin
        phase_t                 ph0;
        logic [VALUE_W-1:0]     acc0, nacc0;
        logic [BASE_W-1:0]      base0, base_use;
        logic [OFFSET_BITS-1:0] pos0, end0;
        logic                   neg0, digit_ok;
        logic [VALUE_W-1:0]     acc_md, nacc_md;

        // Clear state at the first byte of a string
        if (q_item.start)
        begin
            ph0   = PH_START;
            acc0  = '0;
            nacc0 = '0;
            base0 = '0;
            pos0  = '0;
            end0  = '0;
            neg0  = 1'b0;
        end
        else
        begin
            ph0   = phase_reg;
            acc0  = acc_reg;
            nacc0 = nacc_reg;
            base0 = base_reg;
            pos0  = pos_reg;
            end0  = end_reg;
            neg0  = neg_reg;
        end

        // Radix that a digit of this byte is checked against
        if (ph0 == PH_START || ph0 == PH_AFTER_NEG)
        begin
            base_use = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
        end
        else
        begin
            base_use = base0;
        end
        digit_ok = q_item.is_hex && ({1'b0, q_item.digit} < base_use);
        acc_md   = acc0 * VALUE_W'(base_use) + VALUE_W'(q_item.digit);
        nacc_md  = nacc0 * VALUE_W'(base_use) - VALUE_W'(q_item.digit);

        phase_next = ph0;
        acc_next   = acc0;
        nacc_next  = nacc0;
        base_next  = base0;
        neg_next   = neg0;
        end_next   = end0;
        pos_next   = (pos0 == {OFFSET_BITS{1'b1}}) ? pos0 : pos0 + 1'b1;
        taken      = 1'b0;

        case (ph0)
            PH_START, PH_AFTER_NEG:
            begin
                if (ph0 == PH_START && signed_mode && q_item.is_minus)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_AFTER_NEG;
                    taken      = 1'b1;
                end
                else if ((number_base == BASE_AUTO || number_base == BASE_HEX)
                         && q_item.is_zero)
                begin
                    base_next  = (number_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                    phase_next = (number_base == BASE_AUTO) ? PH_ZERO_AUTO : PH_HEX_ZERO;
                    taken      = 1'b1;
                end
                else
                begin
                    base_next = base_use;
                    taken     = digit_ok;
                end
                if (taken)
                begin
                    end_next = pos_next;
                end
            end
            PH_ZERO_AUTO:
            begin
                if (q_item.is_x)
                begin
                    phase_next = PH_AUTO_X;
                end
                else
                begin
                    taken = digit_ok;
                    if (taken)
                    begin
                        end_next = pos_next;
                    end
                end
            end
            PH_AUTO_X:
            begin
                if (q_item.is_hex)
                begin
                    base_next  = BASE_HEX;
                    acc_next   = VALUE_W'(q_item.digit);
                    nacc_next  = '0 - VALUE_W'(q_item.digit);
                    phase_next = PH_DIGITS;
                    taken      = 1'b1;
                    end_next   = pos_next;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_HEX_ZERO:
            begin
                if (q_item.is_x)
                begin
                    phase_next = PH_DIGITS;
                    taken      = 1'b1;
                end
                else
                begin
                    taken = digit_ok;
                end
                if (taken)
                begin
                    end_next = pos_next;
                end
            end
            PH_DIGITS:
            begin
                taken = digit_ok;
                if (taken)
                begin
                    end_next = pos_next;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // Digit handling shared by every phase that tries a digit, but for PH_AUTO_X, which loads its digit itself
        if ((ph0 == PH_START && !(signed_mode && q_item.is_minus)
             && !((number_base == BASE_AUTO || number_base == BASE_HEX) && q_item.is_zero))
            || (ph0 == PH_AFTER_NEG
                && !((number_base == BASE_AUTO || number_base == BASE_HEX) && q_item.is_zero))
            || (ph0 == PH_ZERO_AUTO && !q_item.is_x)
            || (ph0 == PH_HEX_ZERO && !q_item.is_x)
            || ph0 == PH_DIGITS)
        begin
            if (digit_ok)
            begin
                acc_next   = acc_md;
                nacc_next  = nacc_md;
                phase_next = PH_DIGITS;
            end
            else
            begin
                phase_next = PH_DONE;
            end
        end
    end

    // Saturate the end offset to the result field
    always_comb
    begin
        end_ext = EXT_W'(end_next);
        if (end_ext > EXT_W'({END_OFS_W{1'b1}}))
        begin
            end_ofs = {END_OFS_W{1'b1}};
        end
        else
        begin
            end_ofs = end_ext[END_OFS_W-1:0];
        end
    end

    // Load or hold the result stage
    always_comb
    begin
        m_valid_next = (m_valid_reg && !m_tready) || q_pop;
        m_data_next  = m_data_reg;
        if (q_pop)
        begin
            m_data_next = {6'd0, end_ofs, phase_next == PH_DONE, taken,
                           neg_next ? nacc_next : acc_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            acc_reg     <= '0;
            nacc_reg    <= '0;
            base_reg    <= '0;
            pos_reg     <= '0;
            end_reg     <= '0;
            neg_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            if (q_pop)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                nacc_reg  <= nacc_next;
                base_reg  <= base_next;
                pos_reg   <= pos_next;
                end_reg   <= end_next;
                neg_reg   <= neg_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

`ifndef NO_ASSERTIONS
    // The negated copy always tracks the accumulator
    a_nacc_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        nacc_reg == ('0 - acc_reg))
        else $error("negated accumulator out of step");

    // The end offset never runs ahead of the byte offset
    a_end_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
        end_reg <= pos_reg)
        else $error("end offset beyond byte offset");

    // A byte after the number has ended is never taken
    a_done_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && !q_item.start && phase_reg == PH_DONE |=> m_tvalid && !m_tdata[VALUE_W])
        else $error("byte taken after end of number");
`endif

endmodule

// File: hw/rtl/string_to_integer_parser_core.sv
// Top level of the string to integer parser: config registers, front, queue and back.
//
// Usage:
//   Bytes of a string enter on the s_ stream, one request per byte: s_tdata holds
//   the character, s_tuser[0] marks the first byte of a new string and clears the
//   parse state. Every byte yields exactly one result on the m_ stream with the
//   running value (negated when a leading minus was taken in signed mode), whether
//   the byte was taken, whether parsing has ended and the saturating end offset.
//   number_base (index 0) and signed_mode (index 1) are written through cfg_wen,
//   cfg_index and cfg_wdata, by the user while no request is in flight; not enforced.
// Timing:
//   An accepted byte is written into the request queue; the back end pops it from the
//   queue head and loads its result into the registered result stage.
//   One byte per cycle is sustained while m_tready stays high; the back end forms the
//   multiply-add by the radix for the accumulator and its negated copy combinationally.
// Reset and stall:
//   Reset clears the parse state to the start of a string with base 0, unsigned.
//   When m_tready is low the result holds, the two-entry queue fills, and then
//   s_tready drops until the result is taken.
module string_to_integer_parser_core
    import s2i_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic                   cfg_index,
    input  logic [BASE_W-1:0]      cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] char_byte
    input  logic [0:0]             s_tuser,   // [0] string_start
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [63:0] parsed_value, [64] byte_taken,
                                              // [65] parse_done, [81:66] end_offset
);

    logic [BASE_W-1:0] number_base_reg;
    logic              signed_mode_reg;
    logic              q_full, q_push, q_pop, q_valid;
    item_t             push_item, head_item;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= BASE_AUTO;
            signed_mode_reg <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_NUMBER_BASE: number_base_reg <= cfg_wdata;
                REG_SIGNED_MODE: signed_mode_reg <= cfg_wdata[0];
                default:         number_base_reg <= number_base_reg;
            endcase
        end
    end

    s2i_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    s2i_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (head_item)
    );

    s2i_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .number_base (number_base_reg),
        .signed_mode (signed_mode_reg),
        .q_valid     (q_valid),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
